[rtl/core/phas_pkg.sv]
`timescale 1ns / 1ps

package phas_pkg;

   // History geometry
   localparam int TRACK_DEPTH = 64;
   localparam int ADDR_W      = $clog2(TRACK_DEPTH);
   localparam int CNT_W       = $clog2(TRACK_DEPTH + 1);
   localparam int COORD_W     = 8;
   localparam int REQ_W       = 2;
   localparam int DATA_W      = 2 * COORD_W;
   localparam int CMP_W       = (CNT_W > COORD_W) ? CNT_W : COORD_W;

   typedef logic [ADDR_W-1:0]  addr_type;
   typedef logic [CNT_W-1:0]   cnt_type;
   typedef logic [CNT_W:0]     wide_type;
   typedef logic [COORD_W-1:0] coord_type;
   typedef logic [CMP_W-1:0]   cmp_type;
   typedef logic [REQ_W-1:0]   req_code_type;
   typedef logic [DATA_W-1:0]  data_type;

   // Request codes
   localparam req_code_type REQ_CLEAR = 2'd0;
   localparam req_code_type REQ_ADD   = 2'd1;
   localparam req_code_type REQ_QUERY = 2'd2;

   localparam addr_type  ADDR_ONE   = addr_type'(1);
   localparam addr_type  ADDR_LAST  = addr_type'(TRACK_DEPTH - 1);
   localparam cnt_type   CNT_ONE    = cnt_type'(1);
   localparam cnt_type   FILL_FULL  = cnt_type'(TRACK_DEPTH);
   localparam wide_type  WIDE_DEPTH = wide_type'(TRACK_DEPTH);
   localparam coord_type COORD_ONE  = coord_type'(1);
   localparam coord_type COORD_TWO  = coord_type'(2);

   // Controller -> datapath
   typedef struct packed {
      logic take_req;   // transaction accepted this cycle
      logic walk_step;  // move to the next history entry
      logic load_rsp;   // load the output register
      logic rsp_hit;    // result is a match
   } phas_cmd_type;

   // Datapath -> controller
   typedef struct packed {
      logic is_query;
      logic fill_empty;
      logic ent_hit;    // current entry at distance one
      logic ent_stop;   // walk ends without a match
   } phas_sts_type;

endpackage

[rtl/core/phas_req_if.sv]
`timescale 1ns / 1ps

interface phas_req_if;
   logic                   valid;
   logic                   ready;
   phas_pkg::req_code_type req_type;
   phas_pkg::coord_type    pos_x;
   phas_pkg::coord_type    pos_y;

   modport source (output valid, output req_type, output pos_x, output pos_y, input ready);
   modport sink   (input valid, input req_type, input pos_x, input pos_y, output ready);
endinterface

[rtl/core/phas_rsp_if.sv]
`timescale 1ns / 1ps

interface phas_rsp_if;
   logic                valid;
   logic                ready;
   logic                found;
   phas_pkg::coord_type match_x;
   phas_pkg::coord_type match_y;

   modport source (output valid, output found, output match_x, output match_y, input ready);
   modport sink   (input valid, input found, input match_x, input match_y, output ready);
endinterface

[rtl/core/position_history_adjacent_search.sv]
`timescale 1ns / 1ps
// Clear, add, unused code or query on an empty history: result valid the cycle after accept.
// Query: accept reads the newest entry; the walk then reads entries in turn, paced
//   by the one-read-port history RAM whose registered read data feeds the distance compare.
// Throughput: a new transaction is taken once the previous result is loaded and the
//   output register is free; one non-query transaction per cycle when the sink keeps up.
// Reset (synchronous, active high): empties the history and idles the controller; RAM untouched.

module position_history_adjacent_search (
   input  logic        clock,
   input  logic        reset,
   phas_req_if.sink    req_chan,
   phas_rsp_if.source  rsp_chan
);

   phas_pkg::phas_cmd_type cmd;
   phas_pkg::phas_sts_type sts;

   // Sequencer: idle / walk, owns both handshakes and the result valid flag
   phas_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // History RAM, fill count, write pointer, distance compare and result payload
   phas_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .sts      (sts),
      .req_type (req_chan.req_type),
      .pos_x    (req_chan.pos_x),
      .pos_y    (req_chan.pos_y),
      .found    (rsp_chan.found),
      .match_x  (rsp_chan.match_x),
      .match_y  (rsp_chan.match_y)
   );

endmodule

[rtl/core/phas_ram.sv]
`timescale 1ns / 1ps

module phas_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/phas_dp.sv]
`timescale 1ns / 1ps

module phas_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  phas_pkg::phas_cmd_type cmd,
   output phas_pkg::phas_sts_type sts,
   input  phas_pkg::req_code_type req_type,
   input  phas_pkg::coord_type    pos_x,
   input  phas_pkg::coord_type    pos_y,
   output logic                   found,
   output phas_pkg::coord_type    match_x,
   output phas_pkg::coord_type    match_y
);

   phas_pkg::cnt_type   fill_ff, fill_in;
   phas_pkg::addr_type  wslot_ff, wslot_in;
   phas_pkg::addr_type  slot_ff, slot_in;
   phas_pkg::cnt_type   rem_ff, rem_in;
   phas_pkg::coord_type qx_ff, qy_ff;
   logic                found_ff;
   phas_pkg::coord_type mx_ff, my_ff;

   phas_pkg::data_type  rd_data;
   phas_pkg::addr_type  rd_addr;
   phas_pkg::addr_type  start_addr;
   phas_pkg::addr_type  next_addr;
   phas_pkg::coord_type ent_x, ent_y;
   phas_pkg::coord_type dx, dy, cheb, skip;
   phas_pkg::cnt_type   rem_after, rem_next, step;
   phas_pkg::wide_type  diff, diff_wrap;
   logic                skip_out;
   logic                wr_en;

   assign ent_x = rd_data[phas_pkg::DATA_W-1:phas_pkg::COORD_W];
   assign ent_y = rd_data[phas_pkg::COORD_W-1:0];

   // Chebyshev distance to the entry just read
   always_comb begin
      dx   = (qx_ff > ent_x) ? (qx_ff - ent_x) : (ent_x - qx_ff);
      dy   = (qy_ff > ent_y) ? (qy_ff - ent_y) : (ent_y - qy_ff);
      cheb = (dx > dy) ? dx : dy;
      skip = (cheb > phas_pkg::COORD_TWO) ? (cheb - phas_pkg::COORD_TWO) : '0;
   end

   // Remaining count and next slot; step only meaningful when the walk goes on
   always_comb begin
      rem_after = rem_ff - phas_pkg::CNT_ONE;
      skip_out  = phas_pkg::cmp_type'(skip) >= phas_pkg::cmp_type'(rem_after);
      rem_next  = rem_after - phas_pkg::cnt_type'(skip);
      step      = phas_pkg::cnt_type'(skip) + phas_pkg::CNT_ONE;
      diff      = phas_pkg::wide_type'(slot_ff) - phas_pkg::wide_type'(step);
      diff_wrap = diff[phas_pkg::CNT_W] ? (diff + phas_pkg::WIDE_DEPTH) : diff;
      next_addr = phas_pkg::addr_type'(diff_wrap);
      start_addr = (wslot_ff == '0) ? phas_pkg::ADDR_LAST : (wslot_ff - phas_pkg::ADDR_ONE);
      rd_addr   = cmd.take_req ? start_addr : next_addr;
   end

   assign sts.is_query   = (req_type == phas_pkg::REQ_QUERY);
   assign sts.fill_empty = (fill_ff == '0);
   assign sts.ent_hit    = (cheb == phas_pkg::COORD_ONE);
   assign sts.ent_stop   = (cheb == '0) || skip_out;

   assign wr_en = cmd.take_req && (req_type == phas_pkg::REQ_ADD);

   always_comb begin
      fill_in  = fill_ff;
      wslot_in = wslot_ff;
      if (cmd.take_req && (req_type == phas_pkg::REQ_CLEAR)) begin
         fill_in  = '0;
         wslot_in = '0;
      end else if (wr_en) begin
         if (fill_ff < phas_pkg::FILL_FULL) begin
            fill_in = fill_ff + phas_pkg::CNT_ONE;
         end
         wslot_in = (wslot_ff == phas_pkg::ADDR_LAST) ? '0 : (wslot_ff + phas_pkg::ADDR_ONE);
      end
   end

   always_comb begin
      slot_in = slot_ff;
      rem_in  = rem_ff;
      if (cmd.take_req) begin
         slot_in = rd_addr;
         rem_in  = fill_ff;
      end else if (cmd.walk_step) begin
         slot_in = rd_addr;
         rem_in  = rem_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         wslot_ff <= '0;
      end else begin
         fill_ff  <= fill_in;
         wslot_ff <= wslot_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      rem_ff  <= rem_in;
      if (cmd.take_req) begin
         qx_ff <= pos_x;
         qy_ff <= pos_y;
      end
      if (cmd.load_rsp) begin
         found_ff <= cmd.rsp_hit;
         mx_ff    <= cmd.rsp_hit ? ent_x : '0;
         my_ff    <= cmd.rsp_hit ? ent_y : '0;
      end
   end

   phas_ram #(
      .WIDTH (phas_pkg::DATA_W),
      .DEPTH (phas_pkg::TRACK_DEPTH)
   ) u_hist (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wslot_ff),
      .wr_data ({pos_x, pos_y}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign found   = found_ff;
   assign match_x = mx_ff;
   assign match_y = my_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= phas_pkg::FILL_FULL)
      else $error("fill count above depth");

   a_walk_rem: assert property (@(posedge clock) disable iff (reset)
      cmd.walk_step |=> (rem_ff != '0))
      else $error("walk continued with no entries left");

endmodule

[rtl/core/phas_ctrl.sv]
`timescale 1ns / 1ps

module phas_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  phas_pkg::phas_sts_type sts,
   output phas_pkg::phas_cmd_type cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_WALK = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;
   logic req_accept;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign req_ready  = (state_ff == ST_IDLE) && out_free;
   assign req_accept = req_valid && req_ready;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               cmd.take_req = 1'b1;
               if (sts.is_query && !sts.fill_empty) begin
                  state_in = ST_WALK;
               end else begin
                  cmd.load_rsp = 1'b1;
               end
            end
         end
         ST_WALK: begin
            if (sts.ent_hit) begin
               cmd.load_rsp = 1'b1;
               cmd.rsp_hit  = 1'b1;
               state_in     = ST_IDLE;
            end else if (sts.ent_stop) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               cmd.walk_step = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.load_rsp || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> out_free)
      else $error("output register overwritten");

   a_walk_empty_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> !rsp_valid_ff)
      else $error("result pending during walk");

   a_query_walk: assert property (@(posedge clock) disable iff (reset)
      (req_accept && sts.is_query && !sts.fill_empty) |=> (state_ff == ST_WALK))
      else $error("query did not start walk");

endmodule

[dv/tb_position_history_adjacent_search.sv]
`timescale 1ns / 1ps

module tb_position_history_adjacent_search;
   import phas_pkg::*;

   // The package names clear, add and query only; code 3 must be ignored by the block.
   localparam req_code_type REQ_UNUSED = 2'd3;
   localparam int           ITEM_COUNT = 1250;
   localparam int           SETTLE_CYC = 2 * TRACK_DEPTH + 8;

   // ------------------------------------------------------------------
   // Scoreboard: mirrors the history ring and predicts one answer per
   // accepted request transaction, then checks answers in order.
   // ------------------------------------------------------------------
   class adjacency_board;
      typedef struct {
         logic      found;
         coord_type mx;
         coord_type my;
      } answer_t;

      coord_type   trail_x [TRACK_DEPTH];
      coord_type   trail_y [TRACK_DEPTH];
      int          stored;
      int          next_slot;
      answer_t     due_answers [$];
      int          fails;

      function new();
         stored    = 0;
         next_slot = 0;
         fails     = 0;
      endfunction

      // Walk newest -> oldest; far entries make the walk jump over older ones.
      function answer_t search_history(coord_type qx, coord_type qy);
         answer_t ans;
         int      left;
         int      slot;
         int      dx;
         int      dy;
         int      cheb;
         int      skip;
         ans  = '{found: 1'b0, mx: '0, my: '0};
         left = stored;
         slot = next_slot;
         while (left > 0) begin
            left--;
            slot = (slot == 0) ? TRACK_DEPTH - 1 : slot - 1;
            dx   = (int'(qx) > int'(trail_x[slot])) ? int'(qx) - int'(trail_x[slot])
                                                    : int'(trail_x[slot]) - int'(qx);
            dy   = (int'(qy) > int'(trail_y[slot])) ? int'(qy) - int'(trail_y[slot])
                                                    : int'(trail_y[slot]) - int'(qy);
            cheb = (dx > dy) ? dx : dy;
            if (cheb > 2) begin
               skip = cheb - 2;
               left -= skip;
               if (left <= 0) return ans;
               slot = (slot + TRACK_DEPTH - (skip % TRACK_DEPTH)) % TRACK_DEPTH;
            end else if (cheb == 1) begin
               ans.found = 1'b1;
               ans.mx    = trail_x[slot];
               ans.my    = trail_y[slot];
               return ans;
            end else if (cheb == 0) begin
               return ans;
            end
         end
         return ans;
      endfunction

      function void take_request(req_code_type code, coord_type x, coord_type y);
         answer_t ans;
         ans = '{found: 1'b0, mx: '0, my: '0};
         case (code)
            REQ_CLEAR: begin
               stored    = 0;
               next_slot = 0;
            end
            REQ_ADD: begin
               trail_x[next_slot] = x;
               trail_y[next_slot] = y;
               if (stored < TRACK_DEPTH) stored++;
               next_slot = (next_slot + 1) % TRACK_DEPTH;
            end
            REQ_QUERY: ans = search_history(x, y);
            default: ;
         endcase
         due_answers.push_back(ans);
      endfunction

      function void match_answer(logic found, coord_type mx, coord_type my);
         answer_t ans;
         if (due_answers.size() == 0) begin
            $error("unexpected result: found=%0b match_x=%0d match_y=%0d", found, mx, my);
            fails++;
            return;
         end
         ans = due_answers.pop_front();
         if (found !== ans.found) begin
            $error("found: expected %0b, got %0b", ans.found, found);
            fails++;
         end
         if (mx !== ans.mx) begin
            $error("match_x: expected %0d, got %0d", ans.mx, mx);
            fails++;
         end
         if (my !== ans.my) begin
            $error("match_y: expected %0d, got %0d", ans.my, my);
            fails++;
         end
      endfunction

      function int outstanding();
         return due_answers.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   smooth;          // when set, neither side inserts gaps or stalls

   phas_req_if req_chan ();
   phas_rsp_if rsp_chan ();

   adjacency_board board = new();

   // Recently added positions, used to aim queries near live entries.
   int path_x [$];
   int path_y [$];
   int cur_x;
   int cur_y;

   position_history_adjacent_search dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard stop; worst case is far below this (every query walking the whole
   // history plus the longest gap and stall on every transaction).
   initial begin
      #20_000_000;
      $display("Verification failed");
      $finish;
   end

   // Monitors: sample at the rising edge, inputs only move at the falling edge.
   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready)
         board.take_request(req_chan.req_type, req_chan.pos_x, req_chan.pos_y);
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         board.match_answer(rsp_chan.found, rsp_chan.match_x, rsp_chan.match_y);
   end

   // Mostly short holds, now and then a long one.
   function automatic int hold_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic coord_type clip_coord(int v);
      if (v < 0) return '0;
      if (v > 255) return coord_type'(255);
      return coord_type'(v);
   endfunction

   // Result side back-pressure.
   initial begin
      int stall;
      stall = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            stall--;
         end else if (!smooth && $urandom_range(0, 99) < 25) begin
            rsp_chan.ready <= 1'b0;
            stall = hold_length() - 1;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // One request transaction, then an optional gap. With no gap, valid stays
   // high straight into the next transaction.
   task automatic send_request(req_code_type code, coord_type x, coord_type y);
      int gap;
      @(negedge clock);
      req_chan.valid    <= 1'b1;
      req_chan.req_type <= code;
      req_chan.pos_x    <= x;
      req_chan.pos_y    <= y;
      do @(posedge clock); while (!req_chan.ready);
      gap = (!smooth && $urandom_range(0, 99) < 30) ? hold_length() : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_chan.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // Hold off the sender until every outstanding answer has come back.
   task automatic drain_answers();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (board.outstanding() != 0) @(posedge clock);
   endtask

   task automatic add_point(coord_type x, coord_type y);
      path_x.push_back(x);
      path_y.push_back(y);
      if (path_x.size() > TRACK_DEPTH) begin
         void'(path_x.pop_front());
         void'(path_y.pop_front());
      end
      send_request(REQ_ADD, x, y);
   endtask

   // Random traffic: a slowly wandering track of adds, with queries aimed
   // close to recent points so the walk gets past the first few entries.
   task automatic random_item();
      int r;
      int k;
      int span;
      int ox;
      int oy;
      r = $urandom_range(0, 999);
      if (r < 5) begin
         path_x.delete();
         path_y.delete();
         send_request(REQ_CLEAR, coord_type'($urandom_range(0, 255)),
                      coord_type'($urandom_range(0, 255)));
      end else if (r < 25) begin
         send_request(REQ_UNUSED, coord_type'($urandom_range(0, 255)),
                      coord_type'($urandom_range(0, 255)));
      end else if (r < 525) begin
         k = $urandom_range(0, 99);
         if (k < 3) begin
            // jump to a corner
            cur_x = $urandom_range(0, 1) ? 255 : 0;
            cur_y = $urandom_range(0, 1) ? 255 : 0;
         end else if (k < 7) begin
            cur_x = $urandom_range(0, 255);
            cur_y = $urandom_range(0, 255);
         end else begin
            cur_x = clip_coord(cur_x + $urandom_range(0, 4) - 2);
            cur_y = clip_coord(cur_y + $urandom_range(0, 4) - 2);
         end
         add_point(coord_type'(cur_x), coord_type'(cur_y));
      end else begin
         if (path_x.size() == 0 || $urandom_range(0, 99) < 15) begin
            send_request(REQ_QUERY, coord_type'($urandom_range(0, 255)),
                         coord_type'($urandom_range(0, 255)));
         end else begin
            if ($urandom_range(0, 99) < 70) begin
               span = (path_x.size() > 16) ? 15 : path_x.size() - 1;
               k    = path_x.size() - 1 - $urandom_range(0, span);
            end else begin
               k = $urandom_range(0, path_x.size() - 1);
            end
            span = ($urandom_range(0, 99) < 85) ? 3 : 12;
            ox   = $urandom_range(0, 2 * span) - span;
            oy   = $urandom_range(0, 2 * span) - span;
            send_request(REQ_QUERY, clip_coord(path_x[k] + ox), clip_coord(path_y[k] + oy));
         end
      end
   endtask

   initial begin
      smooth            = 1'b0;
      cur_x             = 128;
      cur_y             = 128;
      reset             = 1'b1;
      req_chan.valid    = 1'b0;
      req_chan.req_type = REQ_CLEAR;
      req_chan.pos_x    = '0;
      req_chan.pos_y    = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // ---------------- directed part ----------------
      send_request(REQ_QUERY, 8'd10, 8'd10);     // query on an empty history
      send_request(REQ_UNUSED, 8'd255, 8'd255);  // unused code: ignored, zero result
      send_request(REQ_ADD, 8'd0, 8'd0);
      send_request(REQ_ADD, 8'd255, 8'd255);
      send_request(REQ_ADD, 8'd100, 8'd100);
      send_request(REQ_QUERY, 8'd101, 8'd99);    // distance one: hit on newest
      send_request(REQ_QUERY, 8'd100, 8'd100);   // distance zero stops the walk
      send_request(REQ_QUERY, 8'd102, 8'd100);   // distance two, then skip past oldest
      send_request(REQ_QUERY, 8'd1, 8'd1);       // large skip on the first entry
      send_request(REQ_CLEAR, 8'd77, 8'd33);
      // newest first: (11,11) (12,12) (50,50) (10,10)
      send_request(REQ_ADD, 8'd10, 8'd10);
      send_request(REQ_ADD, 8'd50, 8'd50);
      send_request(REQ_ADD, 8'd12, 8'd12);
      send_request(REQ_ADD, 8'd11, 8'd11);
      // distance 2 moves on, distance 3 skips (50,50), lands on a hit at (10,10)
      send_request(REQ_QUERY, 8'd9, 8'd9);
      send_request(REQ_ADD, 8'd255, 8'd0);
      send_request(REQ_QUERY, 8'd254, 8'd1);     // hit at the coordinate extremes
      send_request(REQ_QUERY, 8'd0, 8'd255);
      send_request(REQ_CLEAR, 8'd255, 8'd255);
      send_request(REQ_QUERY, 8'd100, 8'd100);   // old RAM contents must stay invisible
      send_request(REQ_UNUSED, 8'd0, 8'd0);
      drain_answers();

      // ---------------- random part ----------------
      for (int i = 0; i < ITEM_COUNT; i++) begin
         if (i % 100 == 0) smooth = ($urandom_range(0, 3) == 0);
         if (i % 300 == 150) drain_answers();
         random_item();
      end

      drain_answers();
      // catch any stray result after the last expected one
      repeat (SETTLE_CYC) @(posedge clock);
      if (board.fails == 0 && board.outstanding() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
